### sv/sav_pkg.sv
// Shared types and constants for the scaled affine vertex skinning block.
// Used by the stage control, the dot product and scale stages, and the top level.
package sav_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Widths of the external fields and of the configuration port.
  localparam int FIELD_W      = 32;
  localparam int CFG_NUM_REGS = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int NUM_ROWS     = 3;

  // Pipeline stages, in order of travel.
  localparam int NUM_STAGES = 5;
  localparam int STG_MUL    = 0;  // matrix element times vector component
  localparam int STG_SUM    = 1;  // row sum, truncated
  localparam int STG_WMUL   = 2;  // partial products with the weight
  localparam int STG_ACC    = 3;  // weighted product assembled
  localparam int STG_OUT    = 4;  // addend, clamp, output register

  // Identity matrix with zero translation.
  localparam logic [CFG_DATA_W-1:0] CFG_RESET [CFG_NUM_REGS] = '{
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } sav_stage_ctrl_t;

endpackage

### sv/scaled_affine_vertex_skin.sv
// Top level of the scaled affine vertex skinning block.
// Depends on sav_pkg, sav_stage_ctrl, sav_dot and sav_scale.
//
// Usage:
// - Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at a
//   rising edge; indexes 0 to 5 hold the 3x4 bone matrix, row by row, two
//   Q16.16 columns per register. Other indexes are ignored. Write only while
//   the pipeline is empty.
// - Input channel: one request per vertex (mode, vector, weight, addends),
//   taken when in_valid_i and in_ready_o are both high.
// - Output channel: res_x/y/z and saturated, delivered when out_valid_o and
//   out_ready_i are both high, in the order the requests were taken.
// - Five register stages: element multiply, row sum, weight multiply in two
//   halves, product assembly, addend and clamp into the output register.
//   out_valid_o rises once a taken request reaches the output register.
// - Throughput is one vertex per cycle while the receiver does not stall;
//   each row has its own multipliers.
// - When the receiver stalls, items pile up behind the output register and
//   empty stages keep taking requests until all five stages are full.
// - Reset clears the pipeline valid bits and loads the identity matrix with
//   zero translation.
module scaled_affine_vertex_skin import sav_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic signed [FIELD_W-1:0] vec_x_i,
  input  logic signed [FIELD_W-1:0] vec_y_i,
  input  logic signed [FIELD_W-1:0] vec_z_i,
  input  logic signed [FIELD_W-1:0] weight_i,
  input  logic signed [FIELD_W-1:0] addend_x_i,
  input  logic signed [FIELD_W-1:0] addend_y_i,
  input  logic signed [FIELD_W-1:0] addend_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [FIELD_W-1:0] res_x_o,
  output logic signed [FIELD_W-1:0] res_y_o,
  output logic signed [FIELD_W-1:0] res_z_o,
  output logic                      saturated_o
);

  localparam int SumW = ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ?
                         2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 2;
  localparam int DotW = SumW - FRAC_BITS;
  localparam int HalfW = CFG_DATA_W / 2;

  logic [CFG_DATA_W-1:0]       cfg_q [CFG_NUM_REGS];
  sav_stage_ctrl_t             ctrl;
  logic signed [WORD_BITS-1:0] addend_row [NUM_ROWS];
  logic signed [WORD_BITS-1:0] res_row [NUM_ROWS];
  logic [NUM_ROWS-1:0]         sat_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM_REGS; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < CFG_NUM_REGS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i)) begin
          cfg_q[i] <= cfg_data_i;
        end
      end
    end
  end

  sav_stage_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  assign addend_row[0] = addend_x_i[WORD_BITS-1:0];
  assign addend_row[1] = addend_y_i[WORD_BITS-1:0];
  assign addend_row[2] = addend_z_i[WORD_BITS-1:0];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    logic signed [DotW-1:0]      dot;
    logic signed [WORD_BITS-1:0] weight_d1, addend_d1;

    sav_dot #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_dot (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .m0_i     (cfg_q[2*r][HalfW +: WORD_BITS]),
      .m1_i     (cfg_q[2*r][0 +: WORD_BITS]),
      .m2_i     (cfg_q[2*r+1][HalfW +: WORD_BITS]),
      .m3_i     (cfg_q[2*r+1][0 +: WORD_BITS]),
      .vec_x_i  (vec_x_i[WORD_BITS-1:0]),
      .vec_y_i  (vec_y_i[WORD_BITS-1:0]),
      .vec_z_i  (vec_z_i[WORD_BITS-1:0]),
      .mode_i   (mode_i),
      .weight_i (weight_i[WORD_BITS-1:0]),
      .addend_i (addend_row[r]),
      .dot_o    (dot),
      .weight_o (weight_d1),
      .addend_o (addend_d1)
    );

    sav_scale #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_scale (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .dot_i    (dot),
      .weight_i (weight_d1),
      .addend_i (addend_d1),
      .res_o    (res_row[r]),
      .sat_o    (sat_row[r])
    );
  end

  assign res_x_o     = FIELD_W'(res_row[0]);
  assign res_y_o     = FIELD_W'(res_row[1]);
  assign res_z_o     = FIELD_W'(res_row[2]);
  assign saturated_o = |sat_row;

endmodule

### sv/sav_stage_ctrl.sv
// Valid bits and per-stage load enables of the five-stage pipeline.
// Depends on sav_pkg for the stage count and the control struct.
module sav_stage_ctrl import sav_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sav_stage_ctrl_t ctrl_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] load;

  // A stage may load when it is empty or its item moves on, so bubbles close up.
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign ctrl_o.load = load;

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(valid_q) == $countones($past(valid_q))
             + int'($past(in_valid_i && in_ready_o))
             - int'($past(out_valid_o && out_ready_i)))
    else $error("pipeline occupancy does not match accepted and delivered requests");

  a_ready_on_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> in_ready_o)
    else $error("input held off although a stage is empty");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while the full pipeline is stalled");
`endif

endmodule

### sv/sav_dot.sv
// Stages one and two of a row: element products and the truncated row sum.
// Depends on sav_pkg for stage indices and the control struct.
module sav_dot import sav_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int SumW = ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ?
                         2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 2,
  localparam int DotW = SumW - FRAC_BITS
) (
  input  logic                        clk_i,
  input  sav_stage_ctrl_t             ctrl_i,
  input  logic signed [WORD_BITS-1:0] m0_i,
  input  logic signed [WORD_BITS-1:0] m1_i,
  input  logic signed [WORD_BITS-1:0] m2_i,
  input  logic signed [WORD_BITS-1:0] m3_i,
  input  logic signed [WORD_BITS-1:0] vec_x_i,
  input  logic signed [WORD_BITS-1:0] vec_y_i,
  input  logic signed [WORD_BITS-1:0] vec_z_i,
  input  logic                        mode_i,
  input  logic signed [WORD_BITS-1:0] weight_i,
  input  logic signed [WORD_BITS-1:0] addend_i,
  output logic signed [DotW-1:0]      dot_o,
  output logic signed [WORD_BITS-1:0] weight_o,
  output logic signed [WORD_BITS-1:0] addend_o
);

  localparam int ProdW = 2 * WORD_BITS;

  logic signed [ProdW-1:0]     p0_d, p1_d, p2_d, p0_q, p1_q, p2_q;
  logic signed [SumW-1:0]      trans_d, trans_q, sum_d;
  logic signed [WORD_BITS-1:0] weight_s0_q, addend_s0_q;
  logic signed [DotW-1:0]      dot_q;
  logic signed [WORD_BITS-1:0] weight_s1_q, addend_s1_q;

  assign p0_d = m0_i * vec_x_i;
  assign p1_d = m1_i * vec_y_i;
  assign p2_d = m2_i * vec_z_i;
  // The fourth component is 1.0 for a point and 0 for a direction.
  assign trans_d = mode_i ? '0 : (SumW'(m3_i) <<< FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_MUL]) begin
      p0_q        <= p0_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      trans_q     <= trans_d;
      weight_s0_q <= weight_i;
      addend_s0_q <= addend_i;
    end
  end

  // Exact sum, then floor division by the fraction scale.
  assign sum_d = SumW'(p0_q) + SumW'(p1_q) + SumW'(p2_q) + trans_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_SUM]) begin
      dot_q       <= sum_d[SumW-1:FRAC_BITS];
      weight_s1_q <= weight_s0_q;
      addend_s1_q <= addend_s0_q;
    end
  end

  assign dot_o    = dot_q;
  assign weight_o = weight_s1_q;
  assign addend_o = addend_s1_q;

endmodule

### sv/sav_scale.sv
// Stages three to five of a row: weight multiply in two halves, product assembly, addend and clamp.
// Depends on sav_pkg for stage indices and the control struct.
module sav_scale import sav_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int SumW = ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ?
                         2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 2,
  localparam int DotW = SumW - FRAC_BITS
) (
  input  logic                        clk_i,
  input  sav_stage_ctrl_t             ctrl_i,
  input  logic signed [DotW-1:0]      dot_i,
  input  logic signed [WORD_BITS-1:0] weight_i,
  input  logic signed [WORD_BITS-1:0] addend_i,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        sat_o
);

  localparam int LoW  = (DotW + 1) / 2;
  localparam int HiW  = DotW - LoW;
  localparam int ProdW = DotW + WORD_BITS;
  localparam int LimW = WORD_BITS + FRAC_BITS + 2;
  localparam int CmpW = (ProdW > LimW) ? ProdW : LimW;

  localparam logic signed [CmpW-1:0] LimPos =
    {{(CmpW - WORD_BITS - FRAC_BITS - 1){1'b0}}, 1'b1, {(WORD_BITS + FRAC_BITS){1'b0}}};
  localparam logic signed [CmpW-1:0] LimNeg = -LimPos;
  localparam logic signed [CmpW-1:0] MaxV =
    {{(CmpW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [CmpW-1:0] MinV = ~MaxV;

  logic signed [LoW+WORD_BITS:0]   pl_d, pl_q;
  logic signed [HiW+WORD_BITS-1:0] ph_d, ph_q;
  logic signed [WORD_BITS-1:0]     addend_s2_q, addend_s3_q;
  logic signed [ProdW-1:0]         prod_d, prod_q;
  logic signed [CmpW-1:0]          prod_ext, sum_d;
  logic                            over_hi, over_lo;
  logic signed [WORD_BITS-1:0]     res_d, res_q;
  logic                            sat_d, sat_q;

  // The low half of the row value is unsigned, the high half carries the sign.
  assign pl_d = $signed({1'b0, dot_i[LoW-1:0]}) * weight_i;
  assign ph_d = $signed(dot_i[DotW-1:LoW]) * weight_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_WMUL]) begin
      pl_q        <= pl_d;
      ph_q        <= ph_d;
      addend_s2_q <= addend_i;
    end
  end

  assign prod_d = (ProdW'(ph_q) <<< LoW) + ProdW'(pl_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_ACC]) begin
      prod_q      <= prod_d;
      addend_s3_q <= addend_s2_q;
    end
  end

  // A product beyond the guard saturates toward its own sign, whatever the addend.
  always_comb begin
    prod_ext = CmpW'(prod_q);
    over_hi  = prod_ext > LimPos;
    over_lo  = prod_ext < LimNeg;
    sum_d    = (prod_ext >>> FRAC_BITS) + CmpW'(addend_s3_q);
    if (over_hi) begin
      res_d = MaxV[WORD_BITS-1:0];
      sat_d = 1'b1;
    end else if (over_lo) begin
      res_d = MinV[WORD_BITS-1:0];
      sat_d = 1'b1;
    end else if (sum_d > MaxV) begin
      res_d = MaxV[WORD_BITS-1:0];
      sat_d = 1'b1;
    end else if (sum_d < MinV) begin
      res_d = MinV[WORD_BITS-1:0];
      sat_d = 1'b1;
    end else begin
      res_d = sum_d[WORD_BITS-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_OUT]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule
